>>> design/rbsc_pkg.sv
// Shared types, codes and class masks for the bracket set compiler.
package rbsc_pkg;

  localparam int COUNT_W = 10;
  localparam int STATUS_W = 3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'h3FF;

  localparam logic [STATUS_W-1:0] ST_BRACKET = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NUL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DESCEND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_HEX = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ESC_END = 3'd4;

  // {codes 64..127, codes 0..63}
  localparam logic [127:0] DIGIT_MASK = {64'h0, 64'h03FF_0000_0000_0000};
  localparam logic [127:0] SPACE_MASK = {64'h0, 64'h0000_0001_0000_3E00};
  localparam logic [127:0] WORD_MASK  = {64'h07FF_FFFE_87FF_FFFE, 64'h03FF_0000_0000_0000};

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_SPAN  = 2'd1,
    OP_CLASS = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CLS_DIGIT = 2'd0,
    CLS_SPACE = 2'd1,
    CLS_WORD  = 2'd2
  } class_t;

  typedef struct packed {
    logic [7:0] pattern_byte;
    logic       begins_set;
    logic       negate;
  } pat_t;

  typedef struct packed {
    logic [63:0]         member_bits_low;
    logic [63:0]         member_bits_high;
    logic [COUNT_W-1:0]  bytes_used;
    logic [STATUS_W-1:0] status;
  } res_t;

  // one bitmap update, optionally ending the set
  typedef struct packed {
    logic                begins;
    logic                negated;
    op_t                 op;
    logic [8:0]          first;
    logic [7:0]          last;
    class_t              cls;
    logic                complement;
    logic                finish;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } cmd_t;

endpackage

>>> design/rbsc_front.sv
// Byte parser: tracks escapes, dashes and ranges and issues bitmap commands.
module rbsc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           pat_valid,
  input  rbsc_pkg::pat_t pat,
  input  logic           queue_full,
  output logic           pat_stall,
  output logic           push,
  output rbsc_pkg::cmd_t cmd
);
  import rbsc_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  localparam logic [1:0] PK_NONE    = 2'd0;
  localparam logic [1:0] PK_LITERAL = 2'd1;
  localparam logic [1:0] PK_OTHER   = 2'd2;

  typedef enum logic [3:0] {
    ESC_NONE  = 4'b0001,
    ESC_START = 4'b0010,
    ESC_HEX1  = 4'b0100,
    ESC_HEX2  = 4'b1000
  } esc_t;

  esc_t               escape_phase, escape_phase_next;
  logic               dash_pending, dash_pending_next;
  logic [1:0]         previous_kind, previous_kind_next;
  logic [7:0]         previous_char, previous_char_next;
  logic [3:0]         hex_high_nibble, hex_high_nibble_next;
  logic               negated, negated_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic               finished, finished_next;
  logic               accept;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  assign pat_stall = queue_full;
  assign accept = pat_valid && !queue_full;

  always_comb begin
    logic [7:0] b;
    logic [4:0] hv;
    logic       hit;
    esc_t       ph;
    logic       dp;
    logic [1:0] pk;
    logic [7:0] pc;
    logic       ng;
    logic [COUNT_W-1:0] cnt;

    b = pat.pattern_byte;
    hv = 5'h00;
    hit = 1'b0;
    if (pat.begins_set) begin
      ph = ESC_NONE;
      dp = 1'b0;
      pk = PK_NONE;
      pc = 8'h00;
      ng = pat.negate;
      cnt = '0;
    end else begin
      ph = escape_phase;
      dp = dash_pending;
      pk = previous_kind;
      pc = previous_char;
      ng = negated;
      cnt = byte_count;
    end

    escape_phase_next = ph;
    dash_pending_next = dp;
    previous_kind_next = pk;
    previous_char_next = pc;
    hex_high_nibble_next = pat.begins_set ? 4'h0 : hex_high_nibble;
    negated_next = ng;
    byte_count_next = cnt;
    finished_next = pat.begins_set ? 1'b0 : finished;

    cmd.begins = pat.begins_set;
    cmd.negated = ng;
    cmd.op = OP_NONE;
    cmd.first = {1'b0, b};
    cmd.last = b;
    cmd.cls = CLS_DIGIT;
    cmd.complement = 1'b0;
    cmd.finish = 1'b0;
    cmd.status = ST_BRACKET;
    cmd.count = cnt;

    unique case (ph)
      ESC_START: begin
        escape_phase_next = ESC_NONE;
        case (b) inside
          CH_NUL: begin
            hit = 1'b1;
            cmd.status = ST_ESC_END;
          end
          8'h78: escape_phase_next = ESC_HEX1;
          8'h64, 8'h44, 8'h73, 8'h53, 8'h77, 8'h57: begin
            previous_kind_next = PK_OTHER;
            cmd.op = ng ? OP_NONE : OP_CLASS;
            cmd.complement = (b == 8'h44) || (b == 8'h53) || (b == 8'h57);
            if (b == 8'h64 || b == 8'h44) cmd.cls = CLS_DIGIT;
            else if (b == 8'h73 || b == 8'h53) cmd.cls = CLS_SPACE;
            else cmd.cls = CLS_WORD;
          end
          8'h42, 8'h3C, 8'h3E, 8'h41, 8'h5A, [8'h31:8'h39]:
            previous_kind_next = PK_OTHER;
          default: begin
            logic [7:0] v;
            case (b) inside
              8'h6E: v = 8'd10;
              8'h72: v = 8'd13;
              8'h74: v = 8'd9;
              8'h30: v = 8'd0;
              8'h76: v = 8'd11;
              8'h66: v = 8'd12;
              8'h61: v = 8'd7;
              8'h62: v = 8'd8;
              default: v = b;
            endcase
            cmd.op = OP_SPAN;
            cmd.first = {1'b0, v};
            cmd.last = v;
            previous_char_next = v;
            previous_kind_next = PK_LITERAL;
          end
        endcase
      end
      ESC_HEX1: begin
        hv = hex_value(b);
        if (!hv[4]) begin
          hit = 1'b1;
          cmd.status = ST_BAD_HEX;
        end else begin
          hex_high_nibble_next = hv[3:0];
          escape_phase_next = ESC_HEX2;
        end
      end
      ESC_HEX2: begin
        hv = hex_value(b);
        escape_phase_next = ESC_NONE;
        if (!hv[4] || hex_high_nibble[3]) begin
          hit = 1'b1;
          cmd.status = ST_BAD_HEX;
        end else begin
          cmd.op = OP_SPAN;
          cmd.first = {1'b0, hex_high_nibble, hv[3:0]};
          cmd.last = {hex_high_nibble, hv[3:0]};
          previous_char_next = {hex_high_nibble, hv[3:0]};
          previous_kind_next = PK_LITERAL;
        end
      end
      default: begin
        if (b == CH_CLOSE || b == CH_NUL) begin
          hit = 1'b1;
          cmd.status = (b == CH_NUL) ? ST_NUL : ST_BRACKET;
          if (dp) begin
            cmd.op = OP_SPAN;
            cmd.first = {1'b0, CH_DASH};
            cmd.last = CH_DASH;
          end
        end else if (dp) begin
          dash_pending_next = 1'b0;
          if (pc > b) begin
            hit = 1'b1;
            cmd.status = ST_DESCEND;
          end else begin
            cmd.op = OP_SPAN;
            cmd.first = {1'b0, pc} + 9'd1;
            cmd.last = b;
            previous_kind_next = PK_OTHER;
          end
        end else if (b == CH_BSL) begin
          escape_phase_next = ESC_START;
        end else if (b == CH_DASH) begin
          if (pk == PK_NONE) begin
            cmd.op = OP_SPAN;
            previous_kind_next = PK_OTHER;
          end else if (pk == PK_LITERAL) begin
            dash_pending_next = 1'b1;
          end
        end else begin
          cmd.op = OP_SPAN;
          previous_char_next = b;
          previous_kind_next = PK_LITERAL;
        end
      end
    endcase

    cmd.finish = hit;
    if (hit) begin
      finished_next = 1'b1;
      escape_phase_next = ESC_NONE;
      dash_pending_next = 1'b0;
    end else if (cnt != COUNT_MAX) begin
      byte_count_next = cnt + 1'b1;
    end
  end

  assign push = accept && (pat.begins_set || !finished);

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase <= ESC_NONE;
      dash_pending <= 1'b0;
      previous_kind <= PK_NONE;
      previous_char <= 8'h00;
      hex_high_nibble <= 4'h0;
      negated <= 1'b0;
      byte_count <= '0;
      finished <= 1'b1;
    end else if (push) begin
      escape_phase <= escape_phase_next;
      dash_pending <= dash_pending_next;
      previous_kind <= previous_kind_next;
      previous_char <= previous_char_next;
      hex_high_nibble <= hex_high_nibble_next;
      negated <= negated_next;
      byte_count <= byte_count_next;
      finished <= finished_next;
    end
  end

endmodule

>>> design/rbsc_queue.sv
// Two-entry command queue between parser and bitmap stage.
module rbsc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rbsc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           filled,
  output rbsc_pkg::cmd_t head
);
  import rbsc_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign filled = (fill != 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

>>> design/rbsc_back.sv
// Bitmap stage: applies span and class updates and holds the result register.
module rbsc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  rbsc_pkg::cmd_t cmd,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_stall,
  output rbsc_pkg::res_t res
);
  import rbsc_pkg::*;

  logic [127:0] bitmap, bitmap_next;

  assign pop = cmd_valid && !(res_valid && res_stall);

  always_comb begin
    logic [127:0] base;
    logic [127:0] span;
    logic [127:0] cm;
    base = cmd.begins ? {128{cmd.negated}} : bitmap;
    for (int j = 0; j < 128; j++) begin
      span[j] = (9'(j) >= cmd.first) && (8'(j) <= cmd.last);
    end
    case (cmd.cls)
      CLS_SPACE: cm = SPACE_MASK;
      CLS_WORD:  cm = WORD_MASK;
      default:   cm = DIGIT_MASK;
    endcase
    if (cmd.complement) cm = ~cm;
    case (cmd.op)
      OP_SPAN:  bitmap_next = cmd.negated ? (base & ~span) : (base | span);
      OP_CLASS: bitmap_next = base | cm;
      default:  bitmap_next = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap <= '0;
    end else if (pop) begin
      bitmap <= bitmap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.finish) begin
      res.member_bits_low <= bitmap_next[63:0];
      res.member_bits_high <= bitmap_next[127:64];
      res.bytes_used <= cmd.count;
      res.status <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule

>>> design/regex_bracket_set_compiler.sv
// Top level of the regex bracket set compiler.
// Takes one bracket-body byte per cycle while pat_stall is low and, on the byte that
// ends the set, returns the 128-bit ASCII membership bitmap, the body byte count and
// a status. The parser issues one command per byte of an open set into a two-entry
// queue. Bytes that arrive after a set has ended are taken and dropped. The bitmap
// stage retires one command per cycle while no result is stalled, so the sustained
// rate is one byte per cycle. The ending byte's command passes through a queue slot
// and then the result register before res_valid rises. While a result is stalled
// the bitmap stage holds. Once two commands are waiting in the queue, pat_stall rises.
module regex_bracket_set_compiler (
  input  logic           clk,
  input  logic           rst,
  input  logic           pat_valid,
  output logic           pat_stall,
  input  rbsc_pkg::pat_t pat,
  output logic           res_valid,
  input  logic           res_stall,
  output rbsc_pkg::res_t res
);
  import rbsc_pkg::*;

  logic push, pop, full, filled;
  cmd_t push_cmd, head;

  rbsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pat_valid  (pat_valid),
    .pat        (pat),
    .queue_full (full),
    .pat_stall  (pat_stall),
    .push       (push),
    .cmd        (push_cmd)
  );

  rbsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .filled   (filled),
    .head     (head)
  );

  rbsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (filled),
    .cmd       (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
